### rtl/ppe_pkg.sv
package ppe_pkg;

    // input action codes
    localparam logic [1:0] ACT_HIT  = 2'd0;
    localparam logic [1:0] ACT_MISS = 2'd1;
    localparam logic [1:0] ACT_EOL  = 2'd2;
    localparam logic [1:0] ACT_VIEW = 2'd3;

    // character bytes
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam int NUM_BITS   = 16;
    localparam int DIGIT_BITS = 5;

    // character select codes from controller to datapath
    localparam logic [3:0] SEL_SPACE  = 4'd0;
    localparam logic [3:0] SEL_NUM    = 4'd1;
    localparam logic [3:0] SEL_HASH   = 4'd2;
    localparam logic [3:0] SEL_BANG   = 4'd3;
    localparam logic [3:0] SEL_DIGIT  = 4'd4;
    localparam logic [3:0] SEL_LETTER = 4'd5;
    localparam logic [3:0] SEL_DOT    = 4'd6;
    localparam logic [3:0] SEL_SLASH  = 4'd7;
    localparam logic [3:0] SEL_NL     = 4'd8;
    localparam logic [3:0] SEL_RNUM   = 4'd9;

    typedef struct packed {
        logic       accept;
        logic       miss_inc;
        logic       miss_clr_known;
        logic       eol;
        logic       emit;
        logic [3:0] sel;
        logic       last;
    } ppe_cmd_t;

    typedef struct packed {
        logic out_free;
        logic miss_pend;
        logic region_diff;
        logic solid_need;
        logic high_diff;
        logic num_more;
        logic col_wrap;
    } ppe_stat_t;

endpackage

### rtl/ppe_ctrl.sv
module ppe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [1:0]          s_action,
    input  logic                s_facing,
    input  ppe_pkg::ppe_stat_t  stat,
    output ppe_pkg::ppe_cmd_t   cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_HIT    = 4'd1;
    localparam logic [3:0] S_SPACE  = 4'd2;
    localparam logic [3:0] S_MNUM   = 4'd3;
    localparam logic [3:0] S_HASH   = 4'd4;
    localparam logic [3:0] S_RNUM   = 4'd5;
    localparam logic [3:0] S_BANG   = 4'd6;
    localparam logic [3:0] S_DIGIT  = 4'd7;
    localparam logic [3:0] S_LETTER = 4'd8;
    localparam logic [3:0] S_DOT    = 4'd9;
    localparam logic [3:0] S_SLASH  = 4'd10;
    localparam logic [3:0] S_NL     = 4'd11;

    logic [3:0] state_reg, state_next;
    logic [3:0] ret_reg, ret_next;

    function automatic logic [3:0] after_solid(input ppe_pkg::ppe_stat_t st);
        return st.high_diff ? S_DIGIT : S_LETTER;
    endfunction

    function automatic logic [3:0] after_region(input ppe_pkg::ppe_stat_t st);
        return st.solid_need ? S_BANG : after_solid(st);
    endfunction

    function automatic logic [3:0] after_miss(input ppe_pkg::ppe_stat_t st);
        return st.region_diff ? S_HASH : after_region(st);
    endfunction

    always_comb begin
        logic [3:0] follow;
        logic [3:0] sel;
        logic       emitting;
        logic       col_char;

        cmd        = '0;
        state_next = state_reg;
        ret_next   = ret_reg;
        follow     = S_IDLE;
        sel        = ppe_pkg::SEL_NL;
        emitting   = 1'b0;
        col_char   = 1'b1;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    case (s_action)
                        ppe_pkg::ACT_HIT: begin
                            if (s_facing) begin
                                state_next = S_HIT;
                            end else begin
                                cmd.miss_inc = 1'b1;
                            end
                        end
                        ppe_pkg::ACT_MISS: begin
                            cmd.miss_inc       = 1'b1;
                            cmd.miss_clr_known = 1'b1;
                        end
                        ppe_pkg::ACT_EOL: begin
                            state_next = S_DOT;
                        end
                        default: begin
                            state_next = S_SLASH;
                            ret_next   = S_IDLE;
                        end
                    endcase
                end
            end
            S_HIT: begin
                state_next = stat.miss_pend ? S_SPACE : after_miss(stat);
            end
            S_SPACE: begin
                emitting = 1'b1;
                sel      = ppe_pkg::SEL_SPACE;
                follow   = S_MNUM;
            end
            S_MNUM: begin
                emitting = 1'b1;
                sel      = ppe_pkg::SEL_NUM;
                follow   = stat.num_more ? S_MNUM : after_miss(stat);
            end
            S_HASH: begin
                emitting = 1'b1;
                sel      = ppe_pkg::SEL_HASH;
                follow   = S_RNUM;
            end
            S_RNUM: begin
                emitting = 1'b1;
                sel      = ppe_pkg::SEL_RNUM;
                follow   = stat.num_more ? S_RNUM : after_region(stat);
            end
            S_BANG: begin
                emitting = 1'b1;
                sel      = ppe_pkg::SEL_BANG;
                follow   = after_solid(stat);
            end
            S_DIGIT: begin
                emitting = 1'b1;
                sel      = ppe_pkg::SEL_DIGIT;
                follow   = S_LETTER;
            end
            S_LETTER: begin
                emitting = 1'b1;
                sel      = ppe_pkg::SEL_LETTER;
                follow   = S_IDLE;
            end
            S_DOT: begin
                emitting = 1'b1;
                sel      = ppe_pkg::SEL_DOT;
                follow   = S_IDLE;
            end
            S_SLASH: begin
                emitting = 1'b1;
                col_char = 1'b0;
                sel      = ppe_pkg::SEL_SLASH;
                follow   = S_NL;
            end
            S_NL: begin
                emitting = 1'b1;
                col_char = 1'b0;
                sel      = ppe_pkg::SEL_NL;
                follow   = ret_reg;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase

        if (emitting && stat.out_free) begin
            cmd.emit = 1'b1;
            cmd.sel  = sel;
            cmd.eol  = (state_reg == S_DOT);
            if (col_char && stat.col_wrap) begin
                // inserted newline, then resume the sequence
                state_next = S_NL;
                ret_next   = follow;
                cmd.last   = 1'b0;
            end else begin
                state_next = follow;
                cmd.last   = (follow == S_IDLE);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    assign s_ready = (state_reg == S_IDLE);

endmodule

### rtl/ppe_datapath.sv
module ppe_datapath #(
    parameter int LAST_COLUMN = 74,
    parameter int ID_BITS     = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  ppe_pkg::ppe_cmd_t   cmd,
    output ppe_pkg::ppe_stat_t  stat,
    input  logic [7:0]          s_shade,
    input  logic [15:0]         s_region_id,
    input  logic [15:0]         s_solid_id,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_char,
    output logic                m_last_of_run
);

    localparam int RW = (ID_BITS < ppe_pkg::NUM_BITS) ? ID_BITS : ppe_pkg::NUM_BITS;
    localparam int DB = ppe_pkg::DIGIT_BITS;
    localparam int NB = ppe_pkg::NUM_BITS;
    localparam logic [6:0] LAST_COL = 7'(LAST_COLUMN);

    // latched transaction payload
    logic [7:0]    shade_reg;
    logic [RW-1:0] region_reg;
    logic [15:0]   solid_reg;

    logic [15:0]   miss_reg, miss_next;
    logic [RW-1:0] prev_region_reg, prev_region_next;
    logic [15:0]   prev_solid_reg, prev_solid_next;
    logic          known_reg, known_next;
    logic [2:0]    prev_high_reg, prev_high_next;
    logic [6:0]    column_reg, column_next;
    logic [NB-1:0] num_reg, num_next;

    logic          m_valid_reg, m_valid_next;
    logic [7:0]    m_char_reg, m_char_next;
    logic          m_last_reg, m_last_next;

    logic          col_wrap;
    logic          col_char;

    assign col_wrap = (column_reg >= LAST_COL);
    assign col_char = !(cmd.sel inside {ppe_pkg::SEL_NL, ppe_pkg::SEL_SLASH});

    assign stat.out_free    = !m_valid_reg || m_ready;
    assign stat.miss_pend   = (miss_reg != '0);
    assign stat.region_diff = (region_reg != prev_region_reg);
    assign stat.solid_need  = !known_reg || (prev_solid_reg != solid_reg);
    assign stat.high_diff   = (shade_reg[7:5] != prev_high_reg);
    assign stat.num_more    = (num_reg[NB-1:DB] != '0);
    assign stat.col_wrap    = col_wrap;

    always_comb begin
        miss_next        = miss_reg;
        prev_region_next = prev_region_reg;
        prev_solid_next  = prev_solid_reg;
        known_next       = known_reg;
        prev_high_next   = prev_high_reg;
        column_next      = column_reg;
        num_next         = num_reg;
        m_valid_next     = m_ready ? 1'b0 : m_valid_reg;
        m_char_next      = m_char_reg;
        m_last_next      = m_last_reg;

        if (cmd.miss_inc) begin
            if (miss_reg != 16'hFFFF) begin
                miss_next = miss_reg + 16'd1;
            end
            if (cmd.miss_clr_known) begin
                known_next = 1'b0;
            end
        end

        if (cmd.emit) begin
            m_valid_next = 1'b1;
            m_last_next  = cmd.last;
            case (cmd.sel)
                ppe_pkg::SEL_SPACE: begin
                    m_char_next = ppe_pkg::CH_SPACE;
                    num_next    = miss_reg;
                    miss_next   = '0;
                    known_next  = 1'b0;
                end
                ppe_pkg::SEL_NUM, ppe_pkg::SEL_RNUM: begin
                    m_char_next = ppe_pkg::CH_AT + 8'(num_reg[DB-1:0]);
                    num_next    = num_reg >> DB;
                end
                ppe_pkg::SEL_HASH: begin
                    m_char_next      = ppe_pkg::CH_HASH;
                    num_next         = NB'(region_reg);
                    prev_region_next = region_reg;
                    known_next       = 1'b0;
                end
                ppe_pkg::SEL_BANG: begin
                    m_char_next     = ppe_pkg::CH_BANG;
                    prev_solid_next = solid_reg;
                    known_next      = 1'b1;
                end
                ppe_pkg::SEL_DIGIT: begin
                    m_char_next    = ppe_pkg::CH_ZERO + 8'(shade_reg[7:5]);
                    prev_high_next = shade_reg[7:5];
                end
                ppe_pkg::SEL_LETTER: begin
                    m_char_next = ppe_pkg::CH_AT + 8'(shade_reg[4:0]);
                end
                ppe_pkg::SEL_DOT: begin
                    m_char_next = ppe_pkg::CH_DOT;
                end
                ppe_pkg::SEL_SLASH: begin
                    m_char_next = ppe_pkg::CH_SLASH;
                end
                default: begin
                    m_char_next = ppe_pkg::CH_NL;
                end
            endcase
            if (cmd.eol) begin
                known_next = 1'b0;
                miss_next  = '0;
            end
            if (col_char) begin
                column_next = col_wrap ? 7'd0 : column_reg + 7'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            miss_reg        <= '0;
            prev_region_reg <= '0;
            prev_solid_reg  <= '0;
            known_reg       <= 1'b0;
            prev_high_reg   <= '0;
            column_reg      <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            miss_reg        <= miss_next;
            prev_region_reg <= prev_region_next;
            prev_solid_reg  <= prev_solid_next;
            known_reg       <= known_next;
            prev_high_reg   <= prev_high_next;
            column_reg      <= column_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        num_reg    <= num_next;
        m_char_reg <= m_char_next;
        m_last_reg <= m_last_next;
        if (cmd.accept) begin
            shade_reg  <= s_shade;
            region_reg <= s_region_id[RW-1:0];
            solid_reg  <= s_solid_id;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_out_char    = m_char_reg;
    assign m_last_of_run = m_last_reg;

endmodule

### rtl/pretty_picture_pixel_encoder.sv
// output: a facing hit passes S_HIT before it emits its first character, end of line
// and end of view emit from the state entered on acceptance; misses produce no output
// throughput: one character per cycle from the output register while m_ready is high;
// a facing hit holds s_ready low through S_HIT until all its up to 14 characters
// are emitted, end of line and end of view likewise; misses do not stall the input
// reset: synchronous active-low aresetn clears counters, history and output valid
module pretty_picture_pixel_encoder #(
    parameter int LAST_COLUMN = 74,
    parameter int ID_BITS     = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic        s_facing,
    input  logic [7:0]  s_shade,
    input  logic [15:0] s_region_id,
    input  logic [15:0] s_solid_id,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_out_char,
    output logic        m_last_of_run
);

    ppe_pkg::ppe_cmd_t  cmd;
    ppe_pkg::ppe_stat_t stat;

    ppe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_action (s_action),
        .s_facing (s_facing),
        .stat     (stat),
        .cmd      (cmd)
    );

    ppe_datapath #(
        .LAST_COLUMN (LAST_COLUMN),
        .ID_BITS     (ID_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_shade       (s_shade),
        .s_region_id   (s_region_id),
        .s_solid_id    (s_solid_id),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_char    (m_out_char),
        .m_last_of_run (m_last_of_run)
    );

    // counted transactions never stall the input side
    a_miss_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_action == ppe_pkg::ACT_MISS ||
         (s_action == ppe_pkg::ACT_HIT && !s_facing))) |=> s_ready)
        else $error("miss transaction stalled input");

    // end of view always produces output, so input must stall
    a_view_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_action == ppe_pkg::ACT_VIEW) |=> !s_ready)
        else $error("end of view did not occupy the encoder");

    // slash is always followed by a newline of the same run
    a_slash_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_char == ppe_pkg::CH_SLASH) |-> !m_last_of_run)
        else $error("slash marked as last of run");

endmodule

### sim/pretty_picture_pixel_encoder_test.sv
module pretty_picture_pixel_encoder_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LAST_COL   = 74;
    localparam int N_ROWS     = 22;
    localparam int N_RANDOM   = 50;
    localparam int MISS_RUN   = 40;
    localparam int HOLD_LEN   = 250;
    localparam int CYCLE_MAX  = 40000;

    typedef struct packed {
        logic [1:0]  action;
        logic        facing;
        logic [7:0]  shade;
        logic [15:0] region;
        logic [15:0] solid;
    } pixel_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } char_rec_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_action = ppe_pkg::ACT_HIT;
    logic        s_facing = 1'b0;
    logic [7:0]  s_shade = '0;
    logic [15:0] s_region_id = '0;
    logic [15:0] s_solid_id = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_out_char;
    logic        m_last_of_run;

    pretty_picture_pixel_encoder #(
        .LAST_COLUMN(LAST_COL),
        .ID_BITS(16)
    ) DUT (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_valid(s_valid),
        .s_ready(s_ready),
        .s_action(s_action),
        .s_facing(s_facing),
        .s_shade(s_shade),
        .s_region_id(s_region_id),
        .s_solid_id(s_solid_id),
        .m_valid(m_valid),
        .m_ready(m_ready),
        .m_out_char(m_out_char),
        .m_last_of_run(m_last_of_run)
    );

    always #6 aclk = ~aclk;

    // encoder state mirror
    logic [15:0] miss_run;
    logic [15:0] shown_region;
    logic [15:0] shown_solid;
    logic        solid_shown;
    logic [2:0]  shown_high;
    logic [6:0]  line_col;

    logic [7:0]  pixel_chars[$];
    char_rec_t   expected_chars[$];
    int          row_fifo[$];

    pixel_t      row_px[N_ROWS];
    string       row_want[N_ROWS];

    int          err_count = 0;
    int          cycles = 0;
    bit          steady = 1'b0;
    bit          want_hold = 1'b0;
    bit          hold_done;
    int          hold_left;

    task report_mismatch(input string what, input int got, input int want);
        begin
            $display("mismatch: %s got %0h expected %0h at %0t", what, got, want, $realtime);
            err_count++;
        end
    endtask

    task put_raw(input logic [7:0] c);
        pixel_chars.push_back(c);
    endtask

    // characters counted on the line, newline after the last column
    task put_counted(input logic [7:0] c);
        begin
            put_raw(c);
            if (line_col >= LAST_COL) begin
                put_raw(ppe_pkg::CH_NL);
                line_col = '0;
            end else begin
                line_col = line_col + 7'd1;
            end
        end
    endtask

    // low digit first, at least one digit
    task put_number(input logic [15:0] v);
        logic [15:0] r;
        begin
            r = v;
            put_counted(ppe_pkg::CH_AT + {3'b000, r[4:0]});
            r = r >> ppe_pkg::DIGIT_BITS;
            while (r != 0) begin
                put_counted(ppe_pkg::CH_AT + {3'b000, r[4:0]});
                r = r >> ppe_pkg::DIGIT_BITS;
            end
        end
    endtask

    task encode_pixel(input pixel_t px);
        begin
            pixel_chars.delete();
            if (px.action == ppe_pkg::ACT_MISS ||
                (px.action == ppe_pkg::ACT_HIT && !px.facing)) begin
                if (miss_run != 16'hFFFF) miss_run = miss_run + 16'd1;
                if (px.action == ppe_pkg::ACT_MISS) solid_shown = 1'b0;
            end else if (px.action == ppe_pkg::ACT_HIT) begin
                if (miss_run != 0) begin
                    put_counted(ppe_pkg::CH_SPACE);
                    put_number(miss_run);
                    miss_run = '0;
                    solid_shown = 1'b0;
                end
                if (px.region != shown_region) begin
                    shown_region = px.region;
                    put_counted(ppe_pkg::CH_HASH);
                    put_number(px.region);
                    solid_shown = 1'b0;
                end
                if (!solid_shown || shown_solid != px.solid) begin
                    shown_solid = px.solid;
                    solid_shown = 1'b1;
                    put_counted(ppe_pkg::CH_BANG);
                end
                if (px.shade[7:5] != shown_high) begin
                    shown_high = px.shade[7:5];
                    put_counted(ppe_pkg::CH_ZERO + {5'b00000, px.shade[7:5]});
                end
                put_counted(ppe_pkg::CH_AT + {3'b000, px.shade[4:0]});
            end else if (px.action == ppe_pkg::ACT_EOL) begin
                put_counted(ppe_pkg::CH_DOT);
                solid_shown = 1'b0;
                miss_run = '0;
            end else begin
                put_raw(ppe_pkg::CH_SLASH);
                put_raw(ppe_pkg::CH_NL);
            end
        end
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_MAX) begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: random stalls plus one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (want_hold && !hold_done) begin
            m_ready <= 1'b0;
            hold_left <= HOLD_LEN;
            hold_done <= 1'b1;
        end else if (hold_left != 0) begin
            m_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 33);
        end
    end

    // check characters, then predict for the transaction accepted at this edge
    always @(posedge aclk) begin
        char_rec_t want;
        pixel_t    px;
        int        row;
        if (!aresetn) begin
            miss_run = '0;
            shown_region = '0;
            shown_solid = '0;
            solid_shown = 1'b0;
            shown_high = '0;
            line_col = '0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    report_mismatch("character with none pending", m_out_char, 0);
                end else begin
                    want = expected_chars.pop_front();
                    if (m_out_char !== want.ch)
                        report_mismatch("out_char", m_out_char, want.ch);
                    if (m_last_of_run !== want.last)
                        report_mismatch("last_of_run", m_last_of_run, want.last);
                end
            end
            if (s_valid && s_ready) begin
                px = {s_action, s_facing, s_shade, s_region_id, s_solid_id};
                encode_pixel(px);
                row = row_fifo.pop_front();
                if (row >= 0 && row_want[row].len() > 0) begin
                    for (int i = 0; i < row_want[row].len(); i++)
                        expected_chars.push_back({row_want[row][i],
                                                  i == row_want[row].len() - 1});
                end else begin
                    for (int i = 0; i < pixel_chars.size(); i++)
                        expected_chars.push_back({pixel_chars[i],
                                                  i == pixel_chars.size() - 1});
                end
            end
        end
    end

    task send_pixel(input pixel_t px, input int row);
        begin
            while (!steady && $urandom_range(0, 99) < 33) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
            s_valid <= 1'b1;
            s_action <= px.action;
            s_facing <= px.facing;
            s_shade <= px.shade;
            s_region_id <= px.region;
            s_solid_id <= px.solid;
            row_fifo.push_back(row);
            @(posedge aclk);
            while (!s_ready) @(posedge aclk);
        end
    endtask

    initial begin
        logic [15:0] region_pool[4];
        logic [15:0] solid_pool[4];
        pixel_t      px;
        int          sent;
        int          pick;
        int          burst;

        row_px[0]  = {ppe_pkg::ACT_HIT,  1'b1, 8'h00, 16'h0000, 16'h0000};
        row_want[0] = "!@";
        row_px[1]  = {ppe_pkg::ACT_HIT,  1'b1, 8'hFF, 16'h0000, 16'h0000};
        row_want[1] = "7_";
        row_px[2]  = {ppe_pkg::ACT_MISS, 1'b0, 8'h00, 16'h0000, 16'h0000};
        row_px[3]  = {ppe_pkg::ACT_HIT,  1'b0, 8'hFF, 16'hFFFF, 16'hFFFF};
        row_px[4]  = {ppe_pkg::ACT_HIT,  1'b1, 8'hFF, 16'hFFFF, 16'hFFFF};
        row_want[4] = " B#___A!_";
        row_px[5]  = {ppe_pkg::ACT_EOL,  1'b1, 8'hFF, 16'hFFFF, 16'hFFFF};
        row_want[5] = ".";
        row_px[6]  = {ppe_pkg::ACT_VIEW, 1'b0, 8'h00, 16'h1234, 16'h4321};
        row_want[6] = "/\n";
        row_px[7]  = {ppe_pkg::ACT_HIT,  1'b1, 8'h20, 16'hFFFF, 16'hFFFF};
        row_want[7] = "!1@";
        row_px[8]  = {ppe_pkg::ACT_HIT,  1'b1, 8'h20, 16'h0001, 16'h0000};
        row_want[8] = "#A!@";
        row_px[9]  = {ppe_pkg::ACT_HIT,  1'b1, 8'h3F, 16'h0001, 16'h0005};
        row_want[9] = "!_";
        row_px[10] = {ppe_pkg::ACT_MISS, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF};
        row_px[11] = {ppe_pkg::ACT_HIT,  1'b1, 8'h40, 16'h0001, 16'h0005};
        row_want[11] = " A!2@";
        // back-facing keeps the solid, but the flush clears it anyway
        row_px[12] = {ppe_pkg::ACT_HIT,  1'b0, 8'h00, 16'h0001, 16'h0005};
        row_px[13] = {ppe_pkg::ACT_HIT,  1'b1, 8'h40, 16'h0001, 16'h0005};
        row_want[13] = " A!@";
        row_px[14] = {ppe_pkg::ACT_HIT,  1'b1, 8'h40, 16'h0000, 16'h0005};
        row_want[14] = "#@!@";
        // pending misses dropped by end of line
        row_px[15] = {ppe_pkg::ACT_MISS, 1'b0, 8'h00, 16'h0000, 16'h0000};
        row_px[16] = {ppe_pkg::ACT_EOL,  1'b0, 8'h00, 16'h0000, 16'h0000};
        row_want[16] = ".";
        row_px[17] = {ppe_pkg::ACT_HIT,  1'b1, 8'h40, 16'h0000, 16'h0005};
        row_want[17] = "!@";
        row_px[18] = {ppe_pkg::ACT_VIEW, 1'b1, 8'hFF, 16'hFFFF, 16'hFFFF};
        row_want[18] = "/\n";
        row_px[19] = {ppe_pkg::ACT_HIT,  1'b1, 8'hAA, 16'hAAAA, 16'h5555};
        row_px[20] = {ppe_pkg::ACT_HIT,  1'b1, 8'h55, 16'h5555, 16'hAAAA};
        row_px[21] = {ppe_pkg::ACT_HIT,  1'b1, 8'hE0, 16'h5555, 16'hAAAA};

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < N_ROWS; i++)
            send_pixel(row_px[i], i);

        // run of misses with a two-digit count, then a hit with a long region number
        steady = 1'b1;
        for (int i = 0; i < MISS_RUN; i++) begin
            px = {ppe_pkg::ACT_MISS, 1'($urandom), 8'($urandom), 16'($urandom),
                  16'($urandom)};
            send_pixel(px, -1);
        end
        steady = 1'b0;
        send_pixel({ppe_pkg::ACT_HIT, 1'b1, 8'h1F, 16'h8000, 16'h0003}, -1);

        region_pool[0] = 16'h0000;
        region_pool[1] = 16'hFFFF;
        region_pool[2] = 16'($urandom);
        region_pool[3] = 16'($urandom_range(0, 31));
        solid_pool[0] = 16'h0000;
        solid_pool[1] = 16'hFFFF;
        solid_pool[2] = 16'($urandom);
        solid_pool[3] = 16'($urandom_range(0, 31));

        sent = 0;
        while (sent < N_RANDOM) begin
            steady = (sent >= 10 && sent < 25);
            if (sent >= 30) want_hold = 1'b1;
            px = {2'($urandom), 1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom)};
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                px.action = ppe_pkg::ACT_HIT;
                px.facing = 1'b1;
                if ($urandom_range(0, 4) != 0) px.region = region_pool[$urandom_range(0, 3)];
                if ($urandom_range(0, 4) != 0) px.solid = solid_pool[$urandom_range(0, 3)];
            end else if (pick < 60) begin
                px.action = ppe_pkg::ACT_MISS;
            end else if (pick < 66) begin
                // short run of misses
                burst = $urandom_range(2, 12);
                if (burst > N_RANDOM - sent) burst = N_RANDOM - sent;
                for (int i = 0; i < burst; i++) begin
                    px.action = ppe_pkg::ACT_MISS;
                    send_pixel(px, -1);
                    px = {ppe_pkg::ACT_MISS, 1'($urandom), 8'($urandom), 16'($urandom),
                          16'($urandom)};
                end
                sent = sent + burst;
                continue;
            end else if (pick < 74) begin
                px.action = ppe_pkg::ACT_HIT;
                px.facing = 1'b0;
            end else if (pick < 86) begin
                px.action = ppe_pkg::ACT_EOL;
            end else if (pick < 92) begin
                px.action = ppe_pkg::ACT_VIEW;
            end
            send_pixel(px, -1);
            sent++;
        end
        steady = 1'b0;
        s_valid <= 1'b0;

        @(posedge aclk);
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### sim.f
rtl/ppe_pkg.sv
rtl/ppe_ctrl.sv
rtl/ppe_datapath.sv
rtl/pretty_picture_pixel_encoder.sv
sim/pretty_picture_pixel_encoder_test.sv
